/* hw/rtl/cosine_similarity_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the cosine similarity core
// Both macros expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_CORE_DEFINES_SVH
`define COSINE_SIMILARITY_CORE_DEFINES_SVH

// same-cycle implication
`define CS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/cs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs_pkg
// Widths, queue word type and sequencer states shared by the core.
// ----------------------------------------------------------------------------
package cs_pkg;

	localparam int ElemW   = 16;
	localparam int SqElemW = 2 * ElemW - 1;   // a*a is at most 2^30
	localparam int DotW    = 40;
	localparam int SqW     = 39;
	localparam int CosW    = 16;
	localparam int NormW   = 2 * SqW;         // ssa * ssb
	localparam int ProdW   = 2 * DotW - 1;    // |dot|^2 <= 2^78
	localparam int MulSteps = DotW;
	localparam int StepW   = $clog2(MulSteps);
	localparam int RootW   = CosW - 1;
	localparam int QuoW    = 2 * RootW;
	localparam int RootIdxW = $clog2(RootW);

	localparam int CsQueueDepth = 2;

	typedef struct packed {
		logic [DotW-1:0] dot;
		logic [SqW-1:0]  ssa;
		logic [SqW-1:0]  ssb;
	} cs_sums_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL_N,
		BK_MUL_M,
		BK_DIV,
		BK_SQRT,
		BK_DONE
	} cs_state_t;

endpackage

/* hw/rtl/cs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cs_front
// Registers element products, accumulates dot and square sums, and pushes
// the finished sums of a vector into the queue on the last word.
// ----------------------------------------------------------------------------
module cs_front import cs_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	output logic                    item_stall,
	input  logic signed [ElemW-1:0] elem_a,
	input  logic signed [ElemW-1:0] elem_b,
	input  logic                    last,
	output logic                    push,
	output cs_sums_t                push_data,
	input  logic                    full
);

	logic signed [2*ElemW-1:0] m_ab, m_aa, m_bb;
	logic                      v_s1, last_s1;
	logic signed [2*ElemW-1:0] p_ab_s1;
	logic [SqElemW-1:0]        p_aa_s1, p_bb_s1;
	logic [DotW-1:0]           dot_q, dot_sum;
	logic [SqW-1:0]            ssa_q, ssb_q, ssa_sum, ssb_sum;
	logic                      blocked, fire;

	assign m_ab = elem_a * elem_b;
	assign m_aa = elem_a * elem_a;
	assign m_bb = elem_b * elem_b;

	// only a last word needs room in the queue
	assign blocked    = v_s1 && last_s1 && full;
	assign item_stall = blocked;
	assign fire       = v_s1 && !blocked;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!blocked) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!blocked && item_valid) begin
			last_s1 <= last;
			p_ab_s1 <= m_ab;
			p_aa_s1 <= m_aa[SqElemW-1:0];
			p_bb_s1 <= m_bb[SqElemW-1:0];
		end
	end

	assign dot_sum = dot_q + {{(DotW-2*ElemW){p_ab_s1[2*ElemW-1]}}, p_ab_s1};
	assign ssa_sum = ssa_q + {{(SqW-SqElemW){1'b0}}, p_aa_s1};
	assign ssb_sum = ssb_q + {{(SqW-SqElemW){1'b0}}, p_bb_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			ssa_q <= '0;
			ssb_q <= '0;
		end else if (fire) begin
			if (last_s1) begin
				dot_q <= '0;
				ssa_q <= '0;
				ssb_q <= '0;
			end else begin
				dot_q <= dot_sum;
				ssa_q <= ssa_sum;
				ssb_q <= ssb_sum;
			end
		end
	end

	assign push          = fire && last_s1;
	assign push_data.dot = dot_sum;
	assign push_data.ssa = ssa_sum;
	assign push_data.ssb = ssb_sum;

endmodule

/* hw/rtl/cs_queue.sv */
`timescale 1ns / 1ps
`include "cosine_similarity_core_defines.svh"
// ----------------------------------------------------------------------------
// cs_queue
// Small FIFO of per-vector sums between the accumulator and the sequencer.
// ----------------------------------------------------------------------------
module cs_queue import cs_pkg::*; #(
	parameter int DEPTH = CsQueueDepth
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  cs_sums_t push_data,
	output logic     full,
	input  logic     pop,
	output cs_sums_t pop_data,
	output logic     empty
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	cs_sums_t          mem_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full     = (count_q == CntW'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`CS_ASSERT_IMPL(a_no_overflow, push, !full, "cs_queue: push while full")
	`CS_ASSERT_IMPL(a_no_underflow, pop, !empty, "cs_queue: pop while empty")
	`CS_ASSERT_IMPL(a_count_range, 1'b1, count_q <= CntW'(DEPTH), "cs_queue: count past depth")

endmodule

/* hw/rtl/cs_back.sv */
`timescale 1ns / 1ps
`include "cosine_similarity_core_defines.svh"
// ----------------------------------------------------------------------------
// cs_back
// Sequencer for the cosine: shift-add products of the norms and of |dot|,
// restoring division of |dot|^2 * 2^30 by ssa*ssb, then a bitwise square root.
// ----------------------------------------------------------------------------
module cs_back import cs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	output logic                   pop,
	input  cs_sums_t               pop_data,
	input  logic                   empty,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic signed [CosW-1:0] cosine,
	output logic signed [DotW-1:0] dot_product,
	output logic                   zero_norm
);

	cs_state_t          state_q, state_d;
	logic               out_load;
	logic               pop_zero;
	logic               mul_last, div_last;
	logic [StepW-1:0]   cnt_q;
	logic [DotW-1:0]    dot_q, mag;
	logic               zero_q;
	logic [ProdW-1:0]   prod_q, mc_q, prod_sum, rem2, n_ext;
	logic [DotW-1:0]    mp_q;
	logic [NormW-1:0]   n_q;
	logic [QuoW-1:0]    quo_q;
	logic [RootW-1:0]   root_q, trial;
	logic [QuoW-1:0]    trial_sq;
	logic               rem_ge;
	logic               result_valid_q;
	logic signed [CosW-1:0] cosine_q;
	logic [DotW-1:0]    dot_out_q;
	logic               zero_out_q;

	assign pop_zero = (pop_data.ssa == '0) || (pop_data.ssb == '0);
	assign mul_last = (cnt_q == StepW'(MulSteps - 1));
	assign div_last = (cnt_q == StepW'(QuoW - 1));
	assign mag      = dot_q[DotW-1] ? (~dot_q + 1'b1) : dot_q;
	assign prod_sum = prod_q + (mp_q[0] ? mc_q : '0);
	assign n_ext    = {{(ProdW-NormW){1'b0}}, n_q};
	assign rem2     = {prod_q[ProdW-2:0], 1'b0};
	assign rem_ge   = (rem2 >= n_ext);
	assign trial    = root_q | (RootW'(1) << cnt_q[RootIdxW-1:0]);
	assign trial_sq = trial * trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					pop     = 1'b1;
					state_d = pop_zero ? BK_DONE : BK_MUL_N;
				end
			end
			BK_MUL_N: begin
				if (mul_last) state_d = BK_MUL_M;
			end
			BK_MUL_M: begin
				// |dot|^2 >= ssa*ssb means the cosine saturates
				if (mul_last) state_d = (prod_sum >= n_ext) ? BK_DONE : BK_DIV;
			end
			BK_DIV: begin
				if (div_last) state_d = BK_SQRT;
			end
			BK_SQRT: begin
				if (cnt_q == '0) state_d = BK_DONE;
			end
			BK_DONE: begin
				if (!result_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			unique case (state_q)
				BK_IDLE:  cnt_q <= '0;
				BK_MUL_N: cnt_q <= mul_last ? '0 : cnt_q + 1'b1;
				BK_MUL_M: cnt_q <= mul_last ? '0 : cnt_q + 1'b1;
				BK_DIV:   cnt_q <= div_last ? StepW'(RootW - 1) : cnt_q + 1'b1;
				BK_SQRT:  cnt_q <= cnt_q - 1'b1;
				BK_DONE:  cnt_q <= '0;
				default:  cnt_q <= '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BK_IDLE: begin
				if (pop) begin
					dot_q  <= pop_data.dot;
					zero_q <= pop_zero;
					mc_q   <= {{(ProdW-SqW){1'b0}}, pop_data.ssa};
					mp_q   <= {{(DotW-SqW){1'b0}}, pop_data.ssb};
					prod_q <= '0;
					root_q <= '0;
				end
			end
			BK_MUL_N: begin
				if (mul_last) begin
					n_q    <= prod_sum[NormW-1:0];
					mc_q   <= {{(ProdW-DotW){1'b0}}, mag};
					mp_q   <= mag;
					prod_q <= '0;
				end else begin
					prod_q <= prod_sum;
					mc_q   <= {mc_q[ProdW-2:0], 1'b0};
					mp_q   <= {1'b0, mp_q[DotW-1:1]};
				end
			end
			BK_MUL_M: begin
				prod_q <= prod_sum;
				mc_q   <= {mc_q[ProdW-2:0], 1'b0};
				mp_q   <= {1'b0, mp_q[DotW-1:1]};
				if (mul_last) begin
					quo_q  <= '0;
					root_q <= '1;
				end
			end
			BK_DIV: begin
				prod_q <= rem_ge ? (rem2 - n_ext) : rem2;
				quo_q  <= {quo_q[QuoW-2:0], rem_ge};
				if (div_last) root_q <= '0;
			end
			BK_SQRT: begin
				if (trial_sq <= quo_q) root_q <= trial;
			end
			BK_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			dot_out_q  <= dot_q;
			zero_out_q <= zero_q;
			if (zero_q) begin
				cosine_q <= '0;
			end else if (dot_q[DotW-1]) begin
				cosine_q <= CosW'(0) - {1'b0, root_q};
			end else begin
				cosine_q <= {1'b0, root_q};
			end
		end
	end

	assign result_valid = result_valid_q;
	assign cosine       = cosine_q;
	assign dot_product  = dot_out_q;
	assign zero_norm    = zero_out_q;

	`CS_ASSERT_IMPL(a_zero_cos, result_valid && zero_norm, cosine == '0, "cs_back: zero norm with nonzero cosine")
	`CS_ASSERT_IMPL(a_cos_range, result_valid, cosine != {1'b1, {(CosW-1){1'b0}}}, "cs_back: cosine out of range")
	`CS_ASSERT_NEXT(a_load_done, out_load, state_q == BK_IDLE && result_valid, "cs_back: output load lost")

endmodule

/* hw/rtl/cosine_similarity_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_similarity_core
// Throughput: one element pair per cycle into the accumulators while the queue has room.
// Path from last word to result: the front stage, the queue, the two
// shift-add products, the division steps, the root steps and the output load;
// a saturated cosine skips division and root, a zero norm skips the products too.
// The single sequencer sets the vector rate: one vector at a time, popped only in idle.
// Reset clears accumulators, queue and sequencer at once; no clearing pass.
// ----------------------------------------------------------------------------
module cosine_similarity_core import cs_pkg::*; #(
	parameter int QUEUE_DEPTH = CsQueueDepth
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_stall,
	input  logic signed [ElemW-1:0] elem_a,
	input  logic signed [ElemW-1:0] elem_b,
	input  logic                   last,
	output logic                   result_valid,
	input  logic                   result_stall,
	output logic signed [CosW-1:0] cosine,
	output logic signed [DotW-1:0] dot_product,
	output logic                   zero_norm
);

	logic     push, full, pop, empty;
	cs_sums_t push_data, pop_data;

	cs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.elem_a     (elem_a),
		.elem_b     (elem_b),
		.last       (last),
		.push       (push),
		.push_data  (push_data),
		.full       (full)
	);

	cs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (empty)
	);

	cs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop          (pop),
		.pop_data     (pop_data),
		.empty        (empty),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cosine       (cosine),
		.dot_product  (dot_product),
		.zero_norm    (zero_norm)
	);

endmodule
